### rtl/core/vmapw_pkg.sv
package vmapw_pkg;

  // Default size of the byte memory behind the block.
  localparam int unsigned MEM_BYTES_DEF = 65536;

  // Configuration register port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGING_ENABLE = 1'd0,
    CFG_PAGE_DIR_BASE = 1'd1
  } cfg_reg_e;

  // Access status codes.
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_PRESENT = 2'd1,
    ST_RANGE       = 2'd2
  } status_e;

  // One access request.
  typedef struct packed {
    logic        action;
    logic [31:0] virt_addr;
    logic [2:0]  length;
    logic [31:0] write_data;
  } vmapw_in_t;

  // One access result.
  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] phys_addr;
    logic [1:0]  status;
  } vmapw_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;       // capture a new request
    logic    walk_dir;   // read the directory entry
    logic    walk_tab;   // read the table entry
    logic    rec_walk;   // record the address produced by a walk
    logic    rec_seq;    // record the address that follows the previous byte, or the virtual address for byte zero
    logic    data_req;   // write a byte, or start a byte read
    logic    data_cap;   // capture the byte that was read
    logic    next_byte;  // advance the byte counter
    logic    clr_idx;    // restart the byte counter
    logic    fail;       // record a failure
    status_e fail_code;
    logic    out_load;   // move the result into the output register
  } vmapw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_walk;
    logic last;
    logic wr_access;
    logic dir_oor;
    logic dir_np;
    logic tab_oor;
    logic seq_pa_oor;
    logic walk_pa_oor;
  } vmapw_sts_t;

endpackage

### rtl/core/vmapw_dp.sv
module vmapw_dp #(
  parameter int unsigned MEM_BYTES = vmapw_pkg::MEM_BYTES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  vmapw_pkg::vmapw_in_t                in_data_i,
  input  logic                                cfg_valid_i,
  input  logic [vmapw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [vmapw_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  vmapw_pkg::vmapw_cmd_t               cmd_i,
  output vmapw_pkg::vmapw_sts_t               sts_o,
  output vmapw_pkg::vmapw_out_t               out_data_o
);
  import vmapw_pkg::*;

  localparam int unsigned MEM_WORDS = (MEM_BYTES + 3) / 4;
  localparam int unsigned WAW       = $clog2(MEM_WORDS);
  // An entry fails when any of its four bytes lies beyond the memory.
  localparam logic [31:0] EA_LIMIT  = 32'(MEM_BYTES - 3);
  localparam logic [31:0] PA_LIMIT  = 32'(MEM_BYTES);

  logic        paging_q;
  logic [19:0] pdb_q;

  logic        act_q;
  logic [31:0] va_q;
  logic [1:0]  last_q;
  logic [31:0] wd_q;
  logic [1:0]  idx_q;
  logic [31:0] pa_q [4];
  logic [31:0] last_pa_q;
  logic [31:0] first_pa_q;
  logic [31:0] rd_q;
  status_e     status_q;
  logic [31:0] rdata_q;
  vmapw_out_t  out_q;

  logic [31:0] mem_q [MEM_WORDS];

  logic [1:0]     last_d;
  logic [31:0]    va_cur;
  logic [31:0]    dir_ea;
  logic [31:0]    tab_ea;
  logic [31:0]    seq_pa;
  logic [31:0]    walk_pa;
  logic [31:0]    rec_pa;
  logic [31:0]    mem_addr;
  logic [WAW-1:0] mem_waddr;
  logic [1:0]     mem_lane;
  logic           mem_rd;
  logic           mem_wr;
  logic [7:0]     wr_byte;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paging_q <= 1'b0;
      pdb_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_PAGING_ENABLE: paging_q <= cfg_data_i[0];
        CFG_PAGE_DIR_BASE: pdb_q    <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  // A length of zero acts as one byte, anything above four as four.
  always_comb begin
    case (in_data_i.length)
      3'd0, 3'd1: last_d = 2'd0;
      3'd2:       last_d = 2'd1;
      3'd3:       last_d = 2'd2;
      default:    last_d = 2'd3;
    endcase
  end

  // Address arithmetic for the current byte.
  always_comb begin
    va_cur  = va_q + {30'd0, idx_q};
    dir_ea  = {pdb_q, 12'd0} + {20'd0, va_cur[31:22], 2'd0};
    tab_ea  = {rdata_q[31:12], 12'd0} + {20'd0, va_cur[21:12], 2'd0};
    seq_pa  = (idx_q == 2'd0) ? va_q : last_pa_q + 32'd1;
    walk_pa = {rdata_q[31:12], va_cur[11:0]};
    rec_pa  = cmd_i.rec_walk ? walk_pa : seq_pa;
  end

  // Status toward the controller. Bytes on the same page reuse the last walk.
  always_comb begin
    sts_o.need_walk   = paging_q && ((idx_q == 2'd0) || (va_cur[11:0] == 12'd0));
    sts_o.last        = (idx_q == last_q);
    sts_o.wr_access   = act_q;
    sts_o.dir_oor     = (dir_ea >= EA_LIMIT);
    sts_o.dir_np      = !rdata_q[0];
    sts_o.tab_oor     = (tab_ea >= EA_LIMIT);
    sts_o.seq_pa_oor  = (seq_pa >= PA_LIMIT);
    sts_o.walk_pa_oor = (walk_pa >= PA_LIMIT);
  end

  // Memory port selection.
  always_comb begin
    if (cmd_i.walk_dir) begin
      mem_addr = dir_ea;
    end else if (cmd_i.walk_tab) begin
      mem_addr = tab_ea;
    end else begin
      mem_addr = pa_q[idx_q];
    end
    mem_waddr = mem_addr[WAW+1:2];
    mem_lane  = mem_addr[1:0];
    mem_rd    = cmd_i.walk_dir || cmd_i.walk_tab || (cmd_i.data_req && !act_q);
    mem_wr    = cmd_i.data_req && act_q;
    wr_byte   = wd_q[{idx_q, 3'd0} +: 8];
  end

  // Byte memory, stored as words with per-lane writes and a registered read.
  always_ff @(posedge clk_i) begin
    if (mem_rd) begin
      rdata_q <= mem_q[mem_waddr];
    end
    for (int l = 0; l < 4; l++) begin
      if (mem_wr && (mem_lane == 2'(l))) begin
        mem_q[mem_waddr][8*l +: 8] <= wr_byte;
      end
    end
  end

  // Request capture and byte counter.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= in_data_i.action;
      va_q   <= in_data_i.virt_addr;
      wd_q   <= in_data_i.write_data;
      last_q <= last_d;
    end
    if (cmd_i.load || cmd_i.clr_idx) begin
      idx_q <= 2'd0;
    end else if (cmd_i.next_byte) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  // Translated addresses; the first byte's address is reported.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      first_pa_q <= '0;
    end else if ((cmd_i.rec_walk || cmd_i.rec_seq) && (idx_q == 2'd0)) begin
      first_pa_q <= rec_pa;
    end
    if (cmd_i.rec_walk || cmd_i.rec_seq) begin
      pa_q[idx_q] <= rec_pa;
      last_pa_q   <= rec_pa;
    end
  end

  // Status and read data of the access.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q <= ST_OK;
    end else if (cmd_i.fail) begin
      status_q <= cmd_i.fail_code;
    end
    if (cmd_i.load) begin
      rd_q <= '0;
    end else if (cmd_i.data_cap) begin
      rd_q[{idx_q, 3'd0} +: 8] <= rdata_q[{pa_q[idx_q][1:0], 3'd0} +: 8];
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.read_data <= rd_q;
      out_q.phys_addr <= first_pa_q;
      out_q.status    <= status_q;
    end
  end

  assign out_data_o = out_q;

endmodule

### rtl/core/vmapw_ctrl.sv
module vmapw_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  vmapw_pkg::vmapw_sts_t sts_i,
  output vmapw_pkg::vmapw_cmd_t cmd_o
);
  import vmapw_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_XLATE = 8'b0000_0010,
    S_WDIR  = 8'b0000_0100,
    S_WTAB  = 8'b0000_1000,
    S_WEND  = 8'b0001_0000,
    S_DATA  = 8'b0010_0000,
    S_CAPT  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencing of walks and byte accesses.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.fail_code = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_XLATE;
        end
      end
      S_XLATE: begin
        if (sts_i.need_walk) begin
          state_d = S_WDIR;
        end else begin
          cmd_o.rec_seq = 1'b1;
          if (sts_i.seq_pa_oor) begin
            cmd_o.fail      = 1'b1;
            cmd_o.fail_code = ST_RANGE;
            state_d         = S_DONE;
          end else if (sts_i.last) begin
            cmd_o.clr_idx = 1'b1;
            state_d       = S_DATA;
          end else begin
            cmd_o.next_byte = 1'b1;
          end
        end
      end
      S_WDIR: begin
        if (sts_i.dir_oor) begin
          cmd_o.fail      = 1'b1;
          cmd_o.fail_code = ST_RANGE;
          state_d         = S_DONE;
        end else begin
          cmd_o.walk_dir = 1'b1;
          state_d        = S_WTAB;
        end
      end
      S_WTAB: begin
        if (sts_i.dir_np) begin
          cmd_o.fail      = 1'b1;
          cmd_o.fail_code = ST_NOT_PRESENT;
          state_d         = S_DONE;
        end else if (sts_i.tab_oor) begin
          cmd_o.fail      = 1'b1;
          cmd_o.fail_code = ST_RANGE;
          state_d         = S_DONE;
        end else begin
          cmd_o.walk_tab = 1'b1;
          state_d        = S_WEND;
        end
      end
      S_WEND: begin
        cmd_o.rec_walk = 1'b1;
        if (sts_i.walk_pa_oor) begin
          cmd_o.fail      = 1'b1;
          cmd_o.fail_code = ST_RANGE;
          state_d         = S_DONE;
        end else if (sts_i.last) begin
          cmd_o.clr_idx = 1'b1;
          state_d       = S_DATA;
        end else begin
          cmd_o.next_byte = 1'b1;
          state_d         = S_XLATE;
        end
      end
      S_DATA: begin
        cmd_o.data_req = 1'b1;
        if (!sts_i.wr_access) begin
          state_d = S_CAPT;
        end else if (sts_i.last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.next_byte = 1'b1;
        end
      end
      S_CAPT: begin
        cmd_o.data_cap = 1'b1;
        if (sts_i.last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.next_byte = 1'b1;
          state_d         = S_DATA;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid: set when a result is loaded, cleared once it is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### rtl/core/virtual_memory_access_with_page_walk.sv
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_stall_o   vmapw_in_t  (action, address, length, data)
// out       output     out_valid_o / out_stall_i vmapw_out_t (read data, address, status)
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One access at a time shares the single memory port. After acceptance an access
// translates every byte, walking the page tables (when paging is on) for the first
// byte and again where the bytes cross a page, then writes or reads the bytes and
// loads the output register. A fault ends the access at once.
// Reset clears control and configuration; memory contents are undefined until
// written. A stalled result waits in the output register while the next access runs.
module virtual_memory_access_with_page_walk #(
  parameter int unsigned MEM_BYTES = vmapw_pkg::MEM_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  vmapw_pkg::vmapw_in_t             in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output vmapw_pkg::vmapw_out_t            out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [vmapw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [vmapw_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import vmapw_pkg::*;

  vmapw_cmd_t cmd;
  vmapw_sts_t sts;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  vmapw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vmapw_dp #(
    .MEM_BYTES (MEM_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

  // A failed access never returns read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != ST_OK)) |-> (out_data_o.read_data == '0))
    else $error("read data returned with a failing status");

  // Only one access is in flight: an accepted transfer stalls the input next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while an access is in flight");

  // A held result is never overwritten before its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("output register overwritten while stalled");

endmodule

### sim/tb_virtual_memory_access_with_page_walk.sv
`timescale 1ns / 1ps

module tb_virtual_memory_access_with_page_walk;
  import vmapw_pkg::*;

  localparam int unsigned MEM_SIZE     = MEM_BYTES_DEF;
  localparam int          LIMIT_CYCLES = 1_000_000;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          MAX_REPORTS  = 40;

  // Number of low directory and table entries that are filled in.
  localparam int          MAP_ENTRIES  = 64;
  // Address masks that keep both walk indices within the filled entries.
  localparam logic [31:0] VA_MAPPED    = 32'h0FC3_FFFF;
  localparam logic [31:0] VA_LOW_DIR   = 32'h03C3_FFFF;

  // Access kinds carried in the action field.
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Frames that hold the page directory and the page table in the main layout.
  localparam logic [19:0] DIR_FRAME = 20'h00001;
  localparam logic [19:0] TAB_FRAME = 20'h00002;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  vmapw_in_t             in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  vmapw_out_t            out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the block: configuration and byte memory with a written mask.
  logic        pg_on = 1'b0;
  logic [19:0] dir_base = '0;
  bit   [7:0]  mem_img [MEM_SIZE];
  bit          mem_set [MEM_SIZE];
  bit          touch_unwritten;

  vmapw_out_t  pending[$];
  vmapw_out_t  next_result;
  logic [31:0] written_va[$];

  int mismatch_cnt = 0;
  int cycle_cnt = 0;
  int burst_left = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mode_left = 0;
  int stall_mode = 0;

  virtual_memory_access_with_page_walk #(
    .MEM_BYTES(MEM_SIZE)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Little-endian word from the shadow memory; flags bytes never written.
  function automatic logic [31:0] load_word(input logic [31:0] a);
    logic [31:0] v;
    for (int k = 0; k < 4; k++) begin
      if (!mem_set[a + 32'(k)]) touch_unwritten = 1'b1;
      v[8*k +: 8] = mem_img[a + 32'(k)];
    end
    return v;
  endfunction

  // Two-level translation of one byte address.
  function automatic status_e translate(input logic [31:0] va, output logic [31:0] pa);
    logic [31:0] ea;
    logic [31:0] dir_entry;
    logic [31:0] tab_entry;
    pa = '0;
    if (!pg_on) begin
      pa = va;
      return ST_OK;
    end
    ea = {dir_base, 12'h000} + {20'h0, va[31:22], 2'b00};
    if (ea > MEM_SIZE - 4) return ST_RANGE;
    dir_entry = load_word(ea);
    if (!dir_entry[0]) return ST_NOT_PRESENT;
    ea = {dir_entry[31:12], 12'h000} + {20'h0, va[21:12], 2'b00};
    if (ea > MEM_SIZE - 4) return ST_RANGE;
    tab_entry = load_word(ea);
    pa = {tab_entry[31:12], va[11:0]};
    return ST_OK;
  endfunction

  // Expected result of one access; the shadow memory changes only when commit is set.
  function automatic vmapw_out_t predict_access(input vmapw_in_t it, input bit commit);
    vmapw_out_t  r;
    logic [31:0] pa_list [4];
    logic [31:0] pa;
    logic [31:0] first_pa;
    logic [31:0] rd;
    status_e     st;
    status_e     s;
    int          n;
    n = it.length;
    if (n == 0) n = 1;
    if (n > 4) n = 4;
    st = ST_OK;
    first_pa = '0;
    rd = '0;
    // Every byte is translated before any data moves, so a failure stores nothing.
    for (int i = 0; i < n && st == ST_OK; i++) begin
      s = translate(it.virt_addr + 32'(i), pa);
      if (s == ST_OK && i == 0) first_pa = pa;
      if (s == ST_OK && pa >= MEM_SIZE) s = ST_RANGE;
      st = s;
      pa_list[i] = pa;
    end
    if (st == ST_OK) begin
      for (int i = 0; i < n; i++) begin
        if (it.action == ACT_WRITE) begin
          if (commit) begin
            mem_img[pa_list[i]] = it.write_data[8*i +: 8];
            mem_set[pa_list[i]] = 1'b1;
          end
        end else begin
          if (!mem_set[pa_list[i]]) touch_unwritten = 1'b1;
          rd[8*i +: 8] = mem_img[pa_list[i]];
        end
      end
    end
    r.read_data = rd;
    r.phys_addr = first_pa;
    r.status    = st;
    return r;
  endfunction

  function automatic vmapw_in_t mk_access(input logic act, input logic [31:0] va,
                                          input logic [2:0] len, input logic [31:0] wd);
    vmapw_in_t it;
    it.action     = act;
    it.virt_addr  = va;
    it.length     = len;
    it.write_data = wd;
    return it;
  endfunction

  // Random access; reads mostly revisit addresses that were stored recently.
  function automatic vmapw_in_t rand_access(input logic [31:0] va_mask);
    vmapw_in_t it;
    it.action     = ($urandom_range(0, 1) == 0) ? ACT_READ : ACT_WRITE;
    it.length     = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                : 3'($urandom_range(1, 4));
    it.write_data = $urandom;
    it.virt_addr  = $urandom;
    if ($urandom_range(0, 9) != 0) it.virt_addr &= va_mask;
    // Land near the end of a page so that the access can cross into the next one.
    if ($urandom_range(0, 3) == 0) it.virt_addr[11:0] = 12'hFFC + 12'($urandom_range(0, 3));
    if (it.action == ACT_READ && written_va.size() > 0 && $urandom_range(0, 9) < 7)
      it.virt_addr = written_va[$urandom_range(0, written_va.size() - 1)];
    return it;
  endfunction

  // One input transfer, then the sender's burst and gap pattern.
  task automatic do_access(input vmapw_in_t it);
    int gap;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending.push_back(predict_access(it, 1'b1));
    if (it.action == ACT_WRITE && pending[$].status == ST_OK) begin
      written_va.push_back(it.virt_addr);
      if (written_va.size() > 64) void'(written_va.pop_front());
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : int'($urandom_range(0, 15));
      gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 6));
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Sends an access unless it would read memory that was never written.
  // Such a read becomes a write to the same place when its walks are clean.
  task automatic issue(input vmapw_in_t it);
    touch_unwritten = 1'b0;
    void'(predict_access(it, 1'b0));
    if (touch_unwritten && it.action == ACT_READ) begin
      it.action = ACT_WRITE;
      touch_unwritten = 1'b0;
      void'(predict_access(it, 1'b0));
    end
    if (!touch_unwritten) do_access(it);
  endtask

  task automatic run_random(input int count, input logic [31:0] va_mask);
    for (int k = 0; k < count; k++) issue(rand_access(va_mask));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending.size() != 0);
  endtask

  // Writes both registers once the block has gone idle.
  task automatic set_config(input logic [31:0] pe_val, input logic [31:0] pdb_val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_PAGE_DIR_BASE;
    cfg_data  <= pdb_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    dir_base = pdb_val[19:0];
    cfg_index <= CFG_PAGING_ENABLE;
    cfg_data  <= pe_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pg_on = pe_val[0];
    cfg_valid <= 1'b0;
    written_va.delete();
  endtask

  // Untranslated accesses: both ends of memory, the range limit and odd lengths.
  task automatic test_flat_access();
    set_config(32'h0, 32'h0);
    issue(mk_access(ACT_WRITE, 32'h0000_0000, 3'd4, 32'hFFFF_FFFF));
    issue(mk_access(ACT_READ,  32'h0000_0000, 3'd4, 32'h0));
    issue(mk_access(ACT_WRITE, 32'h0000_FFFC, 3'd4, 32'h8040_2010));
    issue(mk_access(ACT_READ,  32'h0000_FFFC, 3'd4, 32'h0));
    issue(mk_access(ACT_WRITE, 32'h0000_FFFE, 3'd4, 32'h1122_3344));
    issue(mk_access(ACT_READ,  32'h0000_FFFF, 3'd1, 32'h0));
    issue(mk_access(ACT_READ,  32'h0001_0000, 3'd1, 32'h0));
    issue(mk_access(ACT_WRITE, 32'hFFFF_FFFF, 3'd2, 32'h0000_5555));
    issue(mk_access(ACT_WRITE, 32'h0000_0008, 3'd0, 32'h0000_005A));
    issue(mk_access(ACT_READ,  32'h0000_0008, 3'd0, 32'h0));
    issue(mk_access(ACT_READ,  32'h0000_0000, 3'd5, 32'h0));
    issue(mk_access(ACT_READ,  32'h0000_0000, 3'd6, 32'h0));
    issue(mk_access(ACT_READ,  32'h0000_0000, 3'd7, 32'h0));
    issue(mk_access(ACT_READ,  32'h0000_0001, 3'd3, 32'h0));
    run_random(150, 32'h0000_FFFF);
  endtask

  // Builds the page directory and one page table with paging off.
  // Only the low entries and the last entry of each level are filled in.
  task automatic load_page_tables();
    logic [31:0] e;
    int          pick;
    set_config(32'h0, 32'h0);
    for (int d = 0; d < 1024; d++) begin
      if (d >= MAP_ENTRIES && d != 1023) continue;
      case (d)
        0:       e = {TAB_FRAME, 12'h001};
        1:       e = {TAB_FRAME, 12'h000};
        2:       e = {20'h00010, 12'h001};
        3:       e = {DIR_FRAME, 12'h003};
        1023:    e = {TAB_FRAME, 12'hFFF};
        default: begin
          pick = $urandom_range(0, 9);
          e = $urandom;
          if (pick < 7) begin
            e[31:12] = TAB_FRAME;
            e[0]     = 1'b1;
          end else if (pick == 7) begin
            e[0] = 1'b0;
          end else begin
            e[31:12] = 20'($urandom_range(16, 20'hFFFFF));
            e[0]     = 1'b1;
          end
        end
      endcase
      issue(mk_access(ACT_WRITE, {DIR_FRAME, 12'h000} + 32'(4 * d), 3'd4, e));
    end
    // Table entries point at data frames or past the end of memory.
    for (int t = 0; t < 1024; t++) begin
      if (t >= MAP_ENTRIES && t != 1023) continue;
      case (t)
        0:       e = {20'h00003, 12'h000};
        1:       e = {20'h00004, 12'hABC};
        2:       e = {20'h00010, 12'h000};
        1023:    e = {20'h00005, 12'h001};
        default: begin
          e = $urandom;
          if ($urandom_range(0, 19) < 17) e[31:12] = 20'($urandom_range(3, 15));
          else e[31:12] = 20'($urandom_range(16, 20'hFFFFF));
        end
      endcase
      issue(mk_access(ACT_WRITE, {TAB_FRAME, 12'h000} + 32'(4 * t), 3'd4, e));
    end
  endtask

  // Walk cases: page crossing, missing directory entry, range faults, wrap.
  task automatic test_walk_directed();
    set_config(32'h1, {12'h0, DIR_FRAME});
    issue(mk_access(ACT_WRITE, 32'h0000_0000, 3'd4, 32'h0000_0000));
    issue(mk_access(ACT_READ,  32'h0000_0000, 3'd4, 32'h0));
    issue(mk_access(ACT_WRITE, 32'h0000_0FFE, 3'd4, 32'hFFFF_FFFF));
    issue(mk_access(ACT_READ,  32'h0000_0FFE, 3'd4, 32'h0));
    issue(mk_access(ACT_READ,  32'h0040_0000, 3'd4, 32'h0));
    issue(mk_access(ACT_WRITE, 32'h0000_1FFF, 3'd2, 32'h1234_5678));
    issue(mk_access(ACT_WRITE, 32'h003F_FFFF, 3'd4, 32'hA5A5_A5A5));
    issue(mk_access(ACT_READ,  32'h0080_0123, 3'd1, 32'h0));
    issue(mk_access(ACT_READ,  32'h00C0_0000, 3'd4, 32'h0));
    issue(mk_access(ACT_WRITE, 32'hFFFF_FFFF, 3'd2, 32'h0000_BEEF));
    issue(mk_access(ACT_READ,  32'hFFFF_FFFF, 3'd2, 32'h0));
    issue(mk_access(ACT_READ,  32'h0000_0000, 3'd0, 32'h0));
    issue(mk_access(ACT_WRITE, 32'h0000_0004, 3'd7, 32'h89AB_CDEF));
    issue(mk_access(ACT_READ,  32'h0000_0004, 3'd5, 32'h0));
  endtask

  task automatic test_walk_random();
    run_random(650, VA_MAPPED);
  endtask

  // The receiver holds off for a long stretch while accesses keep coming.
  task automatic test_output_hold();
    hold_req <= hold_req + 1;
    run_random(60, VA_MAPPED);
  endtask

  // Directory in frame zero, reached by small virtual addresses.
  task automatic test_dir_at_frame_zero();
    logic [31:0] e;
    set_config(32'h0, 32'h0);
    for (int d = 0; d < 16; d++) begin
      case (d)
        5:       e = {TAB_FRAME, 12'h000};
        9:       e = {20'hFFFFF, 12'h001};
        default: e = {TAB_FRAME, 12'h001};
      endcase
      issue(mk_access(ACT_WRITE, 32'(4 * d), 3'd4, e));
    end
    set_config(32'hFFFF_FFFF, 32'h0);
    run_random(100, VA_LOW_DIR);
  endtask

  // Highest directory frame: every walk falls outside memory.
  task automatic test_dir_out_of_range();
    set_config(32'h1, 32'hFFFF_FFFF);
    run_random(40, 32'hFFFF_FFFF);
  endtask

  task automatic test_paging_off_again();
    set_config(32'hFFFF_FFFE, 32'h0);
    run_random(60, 32'h0000_FFFF);
  endtask

  // Receiver stall pattern, with a long hold when a test asks for one.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (mode_left[2:0] < 3'd3);
      endcase
    end
  end

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_REPORTS)
        $display("%0t: %s expected %h actual %h", $time, what, want, got);
    end
  endtask

  // Each result transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("%0t: result with no access pending, expected none actual %h",
                   $time, out_data);
      end else begin
        next_result = pending.pop_front();
        check_field("read_data", next_result.read_data, out_data.read_data);
        check_field("phys_addr", next_result.phys_addr, out_data.phys_addr);
        check_field("status", 32'(next_result.status), 32'(out_data.status));
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_flat_access();
    load_page_tables();
    test_walk_directed();
    test_walk_random();
    test_output_hold();
    test_dir_at_frame_zero();
    test_dir_out_of_range();
    test_paging_off_again();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/vmapw_pkg.sv
rtl/core/vmapw_dp.sv
rtl/core/vmapw_ctrl.sv
rtl/core/virtual_memory_access_with_page_walk.sv
sim/tb_virtual_memory_access_with_page_walk.sv
